FILE: sv/gcr_pkg.sv
// Shared types, codes and helpers for the glyph coverage to RGB565 converter.
// No dependencies; imported by RAM, top level, checker and bench.
package gcr_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned PIXEL_W   = 16;
    localparam int unsigned TBL_DEPTH = 256;
    localparam int unsigned TBL_AW    = $clog2(TBL_DEPTH);

    // source_mode codes
    localparam logic [1:0] MODE_MONO = 2'd0;
    localparam logic [1:0] MODE_GRAY = 2'd1;
    localparam logic [1:0] MODE_LCD  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_SOURCE_MODE     = 2'd0;
    localparam logic [1:0] CFG_BGR_ORDER       = 2'd1;
    localparam logic [1:0] CFG_PREBLEND_ENABLE = 2'd2;

    // op codes
    localparam logic OP_CONVERT     = 1'b0;
    localparam logic OP_TABLE_WRITE = 1'b1;

    // table select codes
    localparam logic [1:0] TBL_RED   = 2'd0;
    localparam logic [1:0] TBL_GREEN = 2'd1;
    localparam logic [1:0] TBL_BLUE  = 2'd2;

    localparam logic [PIXEL_W-1:0] PIXEL_FULL = '1;
    localparam logic [PIXEL_W-1:0] PIXEL_NONE = '0;

    // one gamma table port request
    typedef struct packed {
        logic              we;
        logic [TBL_AW-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [TBL_AW-1:0] raddr;
    } t_ram_req;

    function automatic logic [PIXEL_W-1:0] pack565(
        input logic [BYTE_W-1:0] r,
        input logic [BYTE_W-1:0] g,
        input logic [BYTE_W-1:0] b
    );
        pack565 = {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

FILE: sv/gcr_gamma_ram.sv
// One 256 x 8 gamma table: one write port, one read port, registered read data.
// Depends on gcr_pkg.
module gcr_gamma_ram (
    input  logic                         i_clk,
    input  gcr_pkg::t_ram_req            i_req,
    output logic [gcr_pkg::BYTE_W-1:0]   o_rdata
);
    import gcr_pkg::*;

    logic [BYTE_W-1:0] r_mem [TBL_DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/glyph_coverage_to_rgb565.sv
// Glyph coverage to RGB565 converter, top level.
// Depends on gcr_pkg and gcr_gamma_ram.
//
// Usage:
//  - Input channel (i_valid / o_stall): one beat is either a pixel convert
//    (i_op = convert) or a gamma table write (i_op = table write). A beat is
//    taken at a clock edge with i_valid high and o_stall low.
//  - Output channel (o_valid / i_stall): one beat per convert, carrying
//    o_pixel_565. Table writes produce no output beat.
//  - Config channel (i_cfg_valid / o_cfg_ready): register index and data;
//    o_cfg_ready is always high. Write only while the pipe is empty.
//  - Pipeline: three register stages. S1 holds the input beat, S2 holds the
//    chosen channel bytes plus the gamma table read data, S3 is the output
//    register with the packed word. Throughput is one beat per cycle while
//    i_stall is low.
//  - Table writes land when the write beat leaves S1, so a convert that
//    follows, even in the next cycle, reads the new entry.
//  - Stall: each stage loads when it is empty or the stage after it moves,
//    so bubbles collapse; o_stall rises only when all three stages are full
//    and i_stall is high. Nothing is dropped or repeated.
//  - Reset (i_rst_n low, synchronous): all stage valids clear; config goes
//    to gray mode, RGB order, preblend off. Table contents are not cleared.
module glyph_coverage_to_rgb565 (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input beat
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_op,
    input  logic [gcr_pkg::BYTE_W-1:0]    i_sub_first,
    input  logic [gcr_pkg::BYTE_W-1:0]    i_sub_middle,
    input  logic [gcr_pkg::BYTE_W-1:0]    i_sub_last,
    input  logic [1:0]                    i_table_select,
    input  logic [gcr_pkg::TBL_AW-1:0]    i_table_index,
    input  logic [gcr_pkg::BYTE_W-1:0]    i_table_value,
    // output beat
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [gcr_pkg::PIXEL_W-1:0]   o_pixel_565,
    // config writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [gcr_pkg::BYTE_W-1:0]    i_cfg_data
);
    import gcr_pkg::*;

    // config registers
    logic [1:0] r_source_mode;
    logic       r_bgr_order;
    logic       r_preblend_enable;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_mode     <= MODE_GRAY;
            r_bgr_order       <= 1'b0;
            r_preblend_enable <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SOURCE_MODE:     r_source_mode     <= i_cfg_data[1:0];
                CFG_BGR_ORDER:       r_bgr_order       <= i_cfg_data[0];
                CFG_PREBLEND_ENABLE: r_preblend_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // stage advance
    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;

    assign en3     = !r_v3 || !i_stall;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;

    // S1: input register
    logic              r1_op;
    logic [BYTE_W-1:0] r1_first, r1_middle, r1_last;
    logic [1:0]        r1_sel;
    logic [TBL_AW-1:0] r1_idx;
    logic [BYTE_W-1:0] r1_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_op     <= i_op;
            r1_first  <= i_sub_first;
            r1_middle <= i_sub_middle;
            r1_last   <= i_sub_last;
            r1_sel    <= i_table_select;
            r1_idx    <= i_table_index;
            r1_val    <= i_table_value;
        end
    end

    // S1 -> S2: subpixel order, table write or lookup
    logic [BYTE_W-1:0] n_red, n_blue;
    logic              s1_write, s1_read;

    assign n_red    = r_bgr_order ? r1_last  : r1_first;
    assign n_blue   = r_bgr_order ? r1_first : r1_last;
    assign s1_write = r_v1 && en2 && (r1_op == OP_TABLE_WRITE);
    assign s1_read  = en2;

    t_ram_req          req_red, req_green, req_blue;
    logic [BYTE_W-1:0] rd_red, rd_green, rd_blue;

    always_comb begin
        req_red         = '{we: s1_write && (r1_sel == TBL_RED), waddr: r1_idx,
                            wdata: r1_val, re: s1_read, raddr: n_red};
        req_green       = req_red;
        req_green.we    = s1_write && (r1_sel == TBL_GREEN);
        req_green.raddr = r1_middle;
        req_blue        = req_red;
        req_blue.we     = s1_write && (r1_sel == TBL_BLUE);
        req_blue.raddr  = n_blue;
    end

    gcr_gamma_ram u_ram_red   (.i_clk(i_clk), .i_req(req_red),   .o_rdata(rd_red));
    gcr_gamma_ram u_ram_green (.i_clk(i_clk), .i_req(req_green), .o_rdata(rd_green));
    gcr_gamma_ram u_ram_blue  (.i_clk(i_clk), .i_req(req_blue),  .o_rdata(rd_blue));

    // S2: raw channel bytes alongside the table read data
    logic              r2_op;
    logic [BYTE_W-1:0] r2_first, r2_red, r2_green, r2_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_op    <= r1_op;
            r2_first <= r1_first;
            r2_red   <= n_red;
            r2_green <= r1_middle;
            r2_blue  <= n_blue;
        end
    end

    // S2 -> S3: mode select and 565 packing; table writes end here
    logic [BYTE_W-1:0]  lcd_r, lcd_g, lcd_b;
    logic [PIXEL_W-1:0] n_pixel;

    assign lcd_r = r_preblend_enable ? rd_red   : r2_red;
    assign lcd_g = r_preblend_enable ? rd_green : r2_green;
    assign lcd_b = r_preblend_enable ? rd_blue  : r2_blue;

    always_comb begin
        unique case (r_source_mode)
            MODE_MONO: n_pixel = r2_first[0] ? PIXEL_FULL : PIXEL_NONE;
            MODE_GRAY: n_pixel = pack565(r2_first, r2_first, r2_first);
            MODE_LCD:  n_pixel = pack565(lcd_r, lcd_g, lcd_b);
            default:   n_pixel = PIXEL_NONE;
        endcase
    end

    logic [PIXEL_W-1:0] r_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2 && (r2_op == OP_CONVERT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_pixel <= n_pixel;
        end
    end

    assign o_valid     = r_v3;
    assign o_pixel_565 = r_pixel;

endmodule

FILE: sv/gcr_checker.sv
// Port-level checks for glyph_coverage_to_rgb565, attached by bind.
// Depends on gcr_pkg.
module gcr_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_stall,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [gcr_pkg::PIXEL_W-1:0] o_pixel_565
);
    import gcr_pkg::*;

    // output beat held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pixel_565))
        else $error("output beat changed under stall");

    // input side stalls only when the pipe is full and the output is blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output backpressure");

    // a taken output beat frees the input side in the same cycle
    a_stall_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall |-> !o_stall)
        else $error("input stalled while the output moves");

    // reset empties the pipe
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipe not empty after reset");

endmodule

bind glyph_coverage_to_rgb565 gcr_checker u_gcr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_pixel_565(o_pixel_565)
);

FILE: bench/glyph_coverage_to_rgb565_tb.sv
// Self-checking bench for glyph_coverage_to_rgb565: random pixel and gamma-table beats
// checked against an in-bench prediction of the packed RGB565 coverage word.
// Depends on gcr_pkg and the glyph_coverage_to_rgb565 RTL.
module glyph_coverage_to_rgb565_tb;
    import gcr_pkg::*;

    // Codes the package leaves unnamed; both are legal field values
    localparam logic [1:0] MODE_UNUSED = 2'd3;  // source mode 3 packs to zero
    localparam logic [1:0] TBL_UNUSED  = 2'd3;  // table select 3 is dropped

    localparam int ITEMS_PER_PHASE = 22;      // beats in each of the 3 x 7 phases
    localparam int NUM_SETTINGS    = 7;
    localparam int DRAIN_CYCLES    = 8;       // pipe is 3 deep, writes give no beat
    localparam int CYCLE_LIMIT     = 200000;  // far above the slowest legal run

    // One input beat, field by field
    typedef struct {
        logic                op;
        logic [BYTE_W-1:0]   first;
        logic [BYTE_W-1:0]   middle;
        logic [BYTE_W-1:0]   last;
        logic [1:0]          sel;
        logic [TBL_AW-1:0]   idx;
        logic [BYTE_W-1:0]   val;
    } glyph_beat_t;

    // Shadow of the converter: config, gamma tables and the pixels still owed
    class rgb565_scoreboard;
        logic [BYTE_W-1:0]  red_lut   [TBL_DEPTH];
        logic [BYTE_W-1:0]  green_lut [TBL_DEPTH];
        logic [BYTE_W-1:0]  blue_lut  [TBL_DEPTH];
        logic [1:0]         source_mode;
        logic               bgr_order;
        logic               preblend_enable;
        logic [PIXEL_W-1:0] pending_pixels[$];
        int                 errors;

        function new();
            source_mode     = MODE_GRAY;
            bgr_order       = 1'b0;
            preblend_enable = 1'b0;
            errors          = 0;
        endfunction

        function void write_reg_shadow(logic [1:0] idx, logic [BYTE_W-1:0] data);
            case (idx)
                CFG_SOURCE_MODE:     source_mode     = data[1:0];
                CFG_BGR_ORDER:       bgr_order       = data[0];
                CFG_PREBLEND_ENABLE: preblend_enable = data[0];
                default: ;
            endcase
        endfunction

        function logic [PIXEL_W-1:0] predict_pixel(glyph_beat_t b);
            logic [BYTE_W-1:0] r;
            logic [BYTE_W-1:0] g;
            logic [BYTE_W-1:0] bl;
            case (source_mode)
                MODE_MONO: return b.first[0] ? PIXEL_FULL : PIXEL_NONE;
                MODE_GRAY: return {b.first[7:3], b.first[7:2], b.first[7:3]};
                MODE_LCD: begin
                    r  = bgr_order ? b.last : b.first;
                    g  = b.middle;
                    bl = bgr_order ? b.first : b.last;
                    if (preblend_enable) begin
                        r  = red_lut[r];
                        g  = green_lut[g];
                        bl = blue_lut[bl];
                    end
                    return {r[7:3], g[7:2], bl[7:3]};
                end
                default: return PIXEL_NONE;
            endcase
        endfunction

        // accepted input beat: table writes update the shadow, converts owe a pixel
        function void note_beat(glyph_beat_t b);
            if (b.op == OP_TABLE_WRITE) begin
                case (b.sel)
                    TBL_RED:   red_lut[b.idx]   = b.val;
                    TBL_GREEN: green_lut[b.idx] = b.val;
                    TBL_BLUE:  blue_lut[b.idx]  = b.val;
                    default: ;
                endcase
            end else begin
                pending_pixels.push_back(predict_pixel(b));
            end
        endfunction

        task report_mismatch(string msg);
            $display("%0t MISMATCH %s", $realtime, msg);
            errors++;
        endtask

        task check_pixel(logic [PIXEL_W-1:0] got);
            logic [PIXEL_W-1:0] want;
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("pixel_565 %h with nothing pending", got));
            end else begin
                want = pending_pixels.pop_front();
                if (got !== want) begin
                    report_mismatch($sformatf("pixel_565 got %h want %h", got, want));
                end
            end
        endtask
    endclass

    // DUT ports; every input has a known value from time zero
    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_valid        = 1'b0;
    logic                o_stall;
    logic                i_op           = OP_CONVERT;
    logic [BYTE_W-1:0]   i_sub_first    = '0;
    logic [BYTE_W-1:0]   i_sub_middle   = '0;
    logic [BYTE_W-1:0]   i_sub_last     = '0;
    logic [1:0]          i_table_select = TBL_RED;
    logic [TBL_AW-1:0]   i_table_index  = '0;
    logic [BYTE_W-1:0]   i_table_value  = '0;
    logic                o_valid;
    logic                i_stall        = 1'b0;
    logic [PIXEL_W-1:0]  o_pixel_565;
    logic                i_cfg_valid    = 1'b0;
    logic                o_cfg_ready;
    logic [1:0]          i_cfg_index    = CFG_SOURCE_MODE;
    logic [BYTE_W-1:0]   i_cfg_data     = '0;

    int send_idle_pct = 0;  // chance per beat slot that the sender holds off
    int recv_idle_pct = 0;  // chance per cycle that the receiver stalls
    int cycle_count   = 0;

    // Gamma entries written so far, per table. Preblended LCD converts only
    // look up entries listed here, since an unwritten entry has no defined value.
    bit                lut_written [3][TBL_DEPTH];
    logic [BYTE_W-1:0] red_used[$];
    logic [BYTE_W-1:0] green_used[$];
    logic [BYTE_W-1:0] blue_used[$];

    // Settings swept in every idle profile: each register hits both ends,
    // and the unused source mode is in the list as well
    logic [1:0] setting_mode [NUM_SETTINGS] =
        '{MODE_MONO, MODE_GRAY, MODE_LCD, MODE_LCD, MODE_LCD, MODE_LCD, MODE_UNUSED};
    logic       setting_bgr  [NUM_SETTINGS] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    logic       setting_pre  [NUM_SETTINGS] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1};

    rgb565_scoreboard sb = new();

    glyph_coverage_to_rgb565 u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_sub_first    (i_sub_first),
        .i_sub_middle   (i_sub_middle),
        .i_sub_last     (i_sub_last),
        .i_table_select (i_table_select),
        .i_table_index  (i_table_index),
        .i_table_value  (i_table_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_pixel_565    (o_pixel_565),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Receiver backpressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Monitor. Everything is driven at the rising edge, so at the falling edge
    // the handshake and payload are settled and are exactly what the next
    // rising edge will take. Input beats are noted before output beats are
    // checked; with three register stages in between that order never matters.
    always @(negedge i_clk) begin
        glyph_beat_t b;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                b.op     = i_op;
                b.first  = i_sub_first;
                b.middle = i_sub_middle;
                b.last   = i_sub_last;
                b.sel    = i_table_select;
                b.idx    = i_table_index;
                b.val    = i_table_value;
                sb.note_beat(b);
            end
            if (o_valid && !i_stall) begin
                sb.check_pixel(o_pixel_565);
            end
        end
    end

    // Present one beat and hold it until taken. Random hold-off first.
    task automatic send_beat(input glyph_beat_t b);
        logic taken;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_op           <= b.op;
        i_sub_first    <= b.first;
        i_sub_middle   <= b.middle;
        i_sub_last     <= b.last;
        i_table_select <= b.sel;
        i_table_index  <= b.idx;
        i_table_value  <= b.val;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic convert(input logic [BYTE_W-1:0] f, m, l);
        glyph_beat_t b;
        b.op     = OP_CONVERT;
        b.first  = f;
        b.middle = m;
        b.last   = l;
        b.sel    = 2'($urandom_range(0, 3));   // don't-care fields get noise
        b.idx    = TBL_AW'($urandom);
        b.val    = BYTE_W'($urandom);
        send_beat(b);
    endtask

    task automatic table_write(input logic [1:0] sel, input logic [TBL_AW-1:0] idx,
                               input logic [BYTE_W-1:0] val);
        glyph_beat_t b;
        b.op     = OP_TABLE_WRITE;
        b.first  = BYTE_W'($urandom);
        b.middle = BYTE_W'($urandom);
        b.last   = BYTE_W'($urandom);
        b.sel    = sel;
        b.idx    = idx;
        b.val    = val;
        // track coverage of each table in issue order, same order as accepts
        if (sel != TBL_UNUSED && !lut_written[sel][idx]) begin
            lut_written[sel][idx] = 1'b1;
            case (sel)
                TBL_RED:   red_used.push_back(idx);
                TBL_GREEN: green_used.push_back(idx);
                default:   blue_used.push_back(idx);
            endcase
        end
        send_beat(b);
    endtask

    function automatic logic [BYTE_W-1:0] pick_written(input logic [1:0] sel);
        case (sel)
            TBL_RED:   return red_used[$urandom_range(0, red_used.size() - 1)];
            TBL_GREEN: return green_used[$urandom_range(0, green_used.size() - 1)];
            default:   return blue_used[$urandom_range(0, blue_used.size() - 1)];
        endcase
    endfunction

    // Mostly converts; about one beat in five loads a gamma entry
    task automatic random_beat();
        logic [BYTE_W-1:0] r;
        logic [BYTE_W-1:0] g;
        logic [BYTE_W-1:0] bl;
        logic [1:0]        sel;
        if ($urandom_range(0, 99) < 20) begin
            sel = ($urandom_range(0, 19) == 0) ? TBL_UNUSED : 2'($urandom_range(0, 2));
            table_write(sel, TBL_AW'($urandom), BYTE_W'($urandom));
        end else if (sb.source_mode == MODE_LCD && sb.preblend_enable) begin
            // choose channel bytes from written entries, then map back to
            // subpixel order so the swap lands them in the right table
            r  = pick_written(TBL_RED);
            g  = pick_written(TBL_GREEN);
            bl = pick_written(TBL_BLUE);
            if (sb.bgr_order) convert(bl, g, r);
            else              convert(r, g, bl);
        end else begin
            convert(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
        end
    endtask

    // One register write; the config channel goes quiet before the shadow is updated
    task automatic write_reg(input logic [1:0] idx, input logic [BYTE_W-1:0] data);
        logic taken;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end while (!taken);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        sb.write_reg_shadow(idx, data);
    endtask

    // Quiet the input, let every owed pixel arrive, then give in-flight
    // table writes time to leave the pipe before any register changes
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (sb.pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Hang guard
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("glyph_coverage_to_rgb565_tb: FAIL");
        $finish;
    end

    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, no idling. Seed both ends of every table.
        table_write(TBL_RED,   8'h00, 8'hFF);
        table_write(TBL_RED,   8'hFF, 8'h00);
        table_write(TBL_GREEN, 8'h00, 8'hFF);
        table_write(TBL_GREEN, 8'hFF, 8'h00);
        table_write(TBL_BLUE,  8'h00, 8'hFF);
        table_write(TBL_BLUE,  8'hFF, 8'h00);
        table_write(TBL_UNUSED, 8'h55, 8'hAA);   // dropped by the block

        // reset config is gray, RGB, no preblend
        convert(8'h00, 8'hFF, 8'hFF);
        convert(8'hFF, 8'h00, 8'h00);
        convert(8'h81, 8'h5A, 8'hA5);

        // mono: only bit 0 of the first byte counts
        wait_idle();
        write_reg(CFG_SOURCE_MODE, {6'd0, MODE_MONO});
        convert(8'hFE, 8'hFF, 8'hFF);
        convert(8'h01, 8'h00, 8'h00);

        // LCD, one channel at a time
        wait_idle();
        write_reg(CFG_SOURCE_MODE, {6'd0, MODE_LCD});
        convert(8'hFF, 8'h00, 8'h00);
        convert(8'h00, 8'hFF, 8'h00);
        convert(8'h00, 8'h00, 8'hFF);

        // BGR swap moves the first subpixel into blue
        wait_idle();
        write_reg(CFG_BGR_ORDER, 8'd1);
        convert(8'hFF, 8'h00, 8'h00);

        // preblend through the seeded entries only
        wait_idle();
        write_reg(CFG_PREBLEND_ENABLE, 8'd1);
        convert(8'hFF, 8'h00, 8'hFF);
        convert(8'h00, 8'hFF, 8'h00);

        // unused source mode packs to zero
        wait_idle();
        write_reg(CFG_SOURCE_MODE, {6'd0, MODE_UNUSED});
        convert(8'hFF, 8'hFF, 8'hFF);

        // Random part: three idle profiles, each sweeping all settings
        for (int prof = 0; prof < 3; prof++) begin
            case (prof)
                0:       begin send_idle_pct = 29; recv_idle_pct = 69; end
                1:       begin send_idle_pct = 69; recv_idle_pct = 29; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            for (int s = 0; s < NUM_SETTINGS; s++) begin
                wait_idle();
                write_reg(CFG_SOURCE_MODE,     {6'd0, setting_mode[s]});
                write_reg(CFG_BGR_ORDER,       {7'd0, setting_bgr[s]});
                write_reg(CFG_PREBLEND_ENABLE, {7'd0, setting_pre[s]});
                repeat (ITEMS_PER_PHASE) random_beat();
            end
        end

        wait_idle();
        if (sb.errors == 0 && sb.pending_pixels.size() == 0) begin
            $display("glyph_coverage_to_rgb565_tb: PASS");
        end else begin
            $display("glyph_coverage_to_rgb565_tb: FAIL");
        end
        $finish;
    end

endmodule
